@@ hw/rtl/ffl_pkg.sv @@
// Shared types and constants of the free-region allocator.
package ffl_pkg;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SHDN,
      ST_SHUP
   } state_type;

   localparam logic        KIND_ALLOC = 1'b0;
   localparam logic        KIND_FREE  = 1'b1;

   localparam logic [1:0]  STAT_OK    = 2'd0;
   localparam logic [1:0]  STAT_NOFIT = 2'd1;
   localparam logic [1:0]  STAT_FULL  = 2'd2;

   localparam logic [31:0] END_REGION_LENGTH = 32'hFFFF_FFFF;

endpackage

@@ hw/rtl/ffl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ffl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/exact_then_first_fit_free_list.sv @@
// Free-region allocator (exact fit, then first fit) over a RAM-held region list.
//
// Requests: req_kind, req_region_size and req_region_offset are taken at a
// rising edge with start high and busy low. Allocate (kind 0) takes the
// first region of equal length and closes the gap, else splits the first
// longer region. Free (kind 1) inserts the region at the list front.
// Results: rsp_valid strobes for one cycle with rsp_alloc_offset,
// rsp_status, rsp_exact_match and rsp_region_count; the receiver cannot stall,
// busy drops in the strobe cycle so a new request may follow at once.
// Steps from accept to strobe, N regions held (N <= FREE_SLOTS):
//   allocate, exact hit at index k : scan all N, then shift the entries above k down
//   allocate, split or no fit      : scan all N
//   free                           : shift all N up, then write entry 0
//   free with full list            : STAT_FULL, strobe right after the accept edge
// The list RAM has one read and one write port, so the scan and the shifts
// move one entry per cycle.
// After a synchronous reset, the INIT state writes the end-of-space region into
// entry 0; busy is high while it does.
module exact_then_first_fit_free_list #(
   parameter int FREE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_region_size,
   input  logic [31:0] req_region_offset,
   output logic        rsp_valid,
   output logic [31:0] rsp_alloc_offset,
   output logic [1:0]  rsp_status,
   output logic        rsp_exact_match,
   output logic [6:0]  rsp_region_count
);

   localparam int IDX_W   = $clog2(FREE_SLOTS);
   localparam int CNT_W   = $clog2(FREE_SLOTS + 1);
   localparam int ENTRY_W = 64;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FREE_SLOTS);

   ffl_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pidx_ff, pidx_in;

   logic               ex_found_ff, ex_found_in;
   logic [IDX_W-1:0]   ex_idx_ff, ex_idx_in;
   logic [31:0]        ex_off_ff, ex_off_in;
   logic               gt_found_ff, gt_found_in;
   logic [IDX_W-1:0]   gt_idx_ff, gt_idx_in;
   logic [31:0]        gt_off_ff, gt_off_in;
   logic [31:0]        gt_len_ff, gt_len_in;

   logic [31:0]        size_ff;
   logic [31:0]        off_ff;

   logic               rsp_valid_ff;
   logic [31:0]        rsp_off_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_exact_ff;
   logic [6:0]         rsp_count_ff;

   logic               take;
   logic               fin;
   logic [31:0]        fin_off;
   logic [1:0]         fin_status;
   logic               fin_exact;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [31:0]        rd_off;
   logic [31:0]        rd_len;
   logic               walk_done;

   assign rd_off    = rd_data[63:32];
   assign rd_len    = rd_data[31:0];
   assign walk_done = !pend_ff && ((state_ff == ffl_pkg::ST_SHUP) ? (ptr_ff == '0)
                                                                   : (ptr_ff == cnt_ff));

   ffl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FREE_SLOTS)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffl_pkg::ST_INIT: begin
            state_in = ffl_pkg::ST_IDLE;
         end
         ffl_pkg::ST_IDLE: begin
            if (start) begin
               if (req_kind == ffl_pkg::KIND_ALLOC) begin
                  state_in = ffl_pkg::ST_SCAN;
               end else if (cnt_ff != FULL_CNT) begin
                  state_in = ffl_pkg::ST_SHUP;
               end
            end
         end
         ffl_pkg::ST_SCAN: begin
            if (walk_done) begin
               state_in = ex_found_ff ? ffl_pkg::ST_SHDN : ffl_pkg::ST_IDLE;
            end
         end
         ffl_pkg::ST_SHDN, ffl_pkg::ST_SHUP: begin
            if (walk_done) begin
               state_in = ffl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffl_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      take        = 1'b0;
      fin         = 1'b0;
      fin_off     = '0;
      fin_status  = ffl_pkg::STAT_OK;
      fin_exact   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      cnt_in      = cnt_ff;
      ptr_in      = ptr_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      ex_found_in = ex_found_ff;
      ex_idx_in   = ex_idx_ff;
      ex_off_in   = ex_off_ff;
      gt_found_in = gt_found_ff;
      gt_idx_in   = gt_idx_ff;
      gt_off_in   = gt_off_ff;
      gt_len_in   = gt_len_ff;
      case (state_ff)
         ffl_pkg::ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {32'd0, ffl_pkg::END_REGION_LENGTH};
         end
         ffl_pkg::ST_IDLE: begin
            if (start) begin
               take = 1'b1;
               if (req_kind == ffl_pkg::KIND_ALLOC) begin
                  ptr_in      = '0;
                  ex_found_in = 1'b0;
                  gt_found_in = 1'b0;
               end else if (cnt_ff == FULL_CNT) begin
                  fin        = 1'b1;
                  fin_status = ffl_pkg::STAT_FULL;
               end else begin
                  ptr_in = cnt_ff;
               end
            end
         end
         ffl_pkg::ST_SCAN: begin
            if (ptr_ff < cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               pidx_in = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (!ex_found_ff && rd_len == size_ff) begin
                  ex_found_in = 1'b1;
                  ex_idx_in   = pidx_ff;
                  ex_off_in   = rd_off;
               end
               if (!gt_found_ff && rd_len > size_ff) begin
                  gt_found_in = 1'b1;
                  gt_idx_in   = pidx_ff;
                  gt_off_in   = rd_off;
                  gt_len_in   = rd_len;
               end
            end
            if (walk_done) begin
               if (ex_found_ff) begin
                  ptr_in = CNT_W'(ex_idx_ff) + 1'b1;
               end else if (gt_found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = gt_idx_ff;
                  wr_data = {gt_off_ff + size_ff, gt_len_ff - size_ff};
                  fin     = 1'b1;
                  fin_off = gt_off_ff;
               end else begin
                  fin        = 1'b1;
                  fin_status = ffl_pkg::STAT_NOFIT;
               end
            end
         end
         ffl_pkg::ST_SHDN: begin
            if (ptr_ff < cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               pidx_in = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff - 1'b1;
               wr_data = rd_data;
            end
            if (walk_done) begin
               cnt_in    = cnt_ff - 1'b1;
               fin       = 1'b1;
               fin_off   = ex_off_ff;
               fin_exact = 1'b1;
            end
         end
         ffl_pkg::ST_SHUP: begin
            if (ptr_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(ptr_ff - 1'b1);
               pidx_in = IDX_W'(ptr_ff - 1'b1);
               ptr_in  = ptr_ff - 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff + 1'b1;
               wr_data = rd_data;
            end
            if (walk_done) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = {off_ff, size_ff};
               cnt_in  = cnt_ff + 1'b1;
               fin     = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffl_pkg::ST_INIT;
         cnt_ff       <= CNT_W'(1);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      pidx_ff     <= pidx_in;
      ex_found_ff <= ex_found_in;
      ex_idx_ff   <= ex_idx_in;
      ex_off_ff   <= ex_off_in;
      gt_found_ff <= gt_found_in;
      gt_idx_ff   <= gt_idx_in;
      gt_off_ff   <= gt_off_in;
      gt_len_ff   <= gt_len_in;
      if (take) begin
         size_ff <= req_region_size;
         off_ff  <= req_region_offset;
      end
      if (fin) begin
         rsp_off_ff    <= fin_off;
         rsp_status_ff <= fin_status;
         rsp_exact_ff  <= fin_exact;
         rsp_count_ff  <= 7'(cnt_in);
      end
   end

   assign busy             = (state_ff != ffl_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_alloc_offset = rsp_off_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_exact_match  = rsp_exact_ff;
   assign rsp_region_count = rsp_count_ff;

endmodule

@@ tb/sv/exact_then_first_fit_free_list_tb.sv @@
// Self-checking testbench of the exact-fit/first-fit free-region allocator.
`timescale 1ns / 1ps

module exact_then_first_fit_free_list_tb;

   localparam int FREE_SLOTS = 64;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_REQUESTS = 1250;

   typedef struct packed {
      logic        kind;
      logic [31:0] size;
      logic [31:0] offset;
   } request_type;

   typedef struct packed {
      logic [31:0] alloc_offset;
      logic [1:0]  status;
      logic        exact_match;
      logic [6:0]  region_count;
   } grant_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = ffl_pkg::KIND_ALLOC;
   logic [31:0] req_region_size = '0;
   logic [31:0] req_region_offset = '0;
   logic        rsp_valid;
   logic [31:0] rsp_alloc_offset;
   logic [1:0]  rsp_status;
   logic        rsp_exact_match;
   logic [6:0]  rsp_region_count;

   // shadow of the region list
   logic [31:0] shadow_offset [FREE_SLOTS];
   logic [31:0] shadow_length [FREE_SLOTS];
   int          shadow_held = 1;

   request_type pending_requests[$];
   grant_type   expected_grants[$];

   int idle_pct = 0;
   int failures = 0;
   int requests_taken = 0;
   int grants_checked = 0;
   int quiet_cycles = 0;
   int n_exact = 0, n_split = 0, n_nofit = 0, n_freed = 0, n_dropped = 0;

   exact_then_first_fit_free_list #(
      .FREE_SLOTS(FREE_SLOTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_region_size  (req_region_size),
      .req_region_offset(req_region_offset),
      .rsp_valid        (rsp_valid),
      .rsp_alloc_offset (rsp_alloc_offset),
      .rsp_status       (rsp_status),
      .rsp_exact_match  (rsp_exact_match),
      .rsp_region_count (rsp_region_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic allocate_or_free(input request_type r, output grant_type g);
      int hit;
      int i;
      g = '0;
      hit = -1;
      if (r.kind == ffl_pkg::KIND_ALLOC) begin
         for (i = 0; i < shadow_held; i++)
            if (hit < 0 && shadow_length[i] == r.size) hit = i;
         if (hit >= 0) begin
            g.alloc_offset = shadow_offset[hit];
            g.exact_match = 1'b1;
            for (i = hit; i < shadow_held - 1; i++) begin
               shadow_offset[i] = shadow_offset[i + 1];
               shadow_length[i] = shadow_length[i + 1];
            end
            shadow_held--;
            n_exact++;
         end else begin
            for (i = 0; i < shadow_held; i++)
               if (hit < 0 && shadow_length[i] > r.size) hit = i;
            if (hit >= 0) begin
               g.alloc_offset = shadow_offset[hit];
               shadow_offset[hit] = shadow_offset[hit] + r.size;
               shadow_length[hit] = shadow_length[hit] - r.size;
               n_split++;
            end else begin
               g.status = ffl_pkg::STAT_NOFIT;
               n_nofit++;
            end
         end
      end else if (shadow_held >= FREE_SLOTS) begin
         g.status = ffl_pkg::STAT_FULL;
         n_dropped++;
      end else begin
         for (i = shadow_held; i > 0; i--) begin
            shadow_offset[i] = shadow_offset[i - 1];
            shadow_length[i] = shadow_length[i - 1];
         end
         shadow_offset[0] = r.offset;
         shadow_length[0] = r.size;
         shadow_held++;
         n_freed++;
      end
      g.region_count = 7'(shadow_held);
   endtask

   function automatic request_type random_request(bit grow);
      request_type r;
      int       pick;
      int       idx;
      int       exact_pct;
      logic [31:0] len;
      r.offset = $urandom;
      pick = $urandom_range(0, 99);
      idx = (shadow_held > 0) ? $urandom_range(0, shadow_held - 1) : 0;
      len = (shadow_held > 0) ? shadow_length[idx] : $urandom;
      if ($urandom_range(0, 99) < (grow ? 85 : 15)) begin
         r.kind = ffl_pkg::KIND_FREE;
         if (pick < 5) r.size = '0;
         else if (pick < 50) r.size = $urandom_range(1, 256);
         else if (pick < 70) r.size = $urandom;
         else if (pick < 78) r.size = 32'hFFFF_FFFF;
         else r.size = len;
         pick = $urandom_range(0, 9);
         if (pick == 0) r.offset = 32'hFFFF_FF00 + $urandom_range(0, 255);
         else if (pick == 1) r.offset = $urandom_range(0, 4095);
      end else begin
         r.kind = ffl_pkg::KIND_ALLOC;
         exact_pct = grow ? 30 : 70;
         if (pick < exact_pct) r.size = len;
         else if (pick < exact_pct + 12) r.size = (len == 0) ? '0 : $urandom_range(0, len - 1);
         else if (pick < exact_pct + 16) r.size = '0;
         else if (pick < exact_pct + 22) r.size = $urandom;
         else if (pick < exact_pct + 24) r.size = 32'hFFFF_FFFF;
         else r.size = $urandom_range(1, 256);
      end
      return r;
   endfunction

   task automatic queue_request(input logic kind, input logic [31:0] size,
                                input logic [31:0] offset);
      request_type r;
      r.kind = kind;
      r.size = size;
      r.offset = offset;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   // driver
   always @(posedge clock) begin
      request_type r;
      grant_type   g;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            allocate_or_free('{kind: req_kind, size: req_region_size,
                               offset: req_region_offset}, g);
            expected_grants.insert(expected_grants.size(), g);
            requests_taken++;
         end
         if (!start || !busy) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               r = pending_requests.pop_front();
               req_kind <= r.kind;
               req_region_size <= r.size;
               req_region_offset <= r.offset;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_val,
                                       logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         failures++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      grant_type g;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
         end else begin
            g = expected_grants.pop_front();
            check_field("alloc_offset", g.alloc_offset, rsp_alloc_offset);
            check_field("status", 32'(g.status), 32'(rsp_status));
            check_field("exact_match", 32'(g.exact_match), 32'(rsp_exact_match));
            check_field("region_count", 32'(g.region_count), 32'(rsp_region_count));
            grants_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int  ph;
      int  k;
      int  tide_left;
      bit  grow;
      int  phase_idle [4];
      shadow_offset[0] = '0;
      shadow_length[0] = ffl_pkg::END_REGION_LENGTH;
      phase_idle = '{0, 71, 0, 29};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      queue_request(ffl_pkg::KIND_ALLOC, 32'h0, 32'hFFFF_FFFF);
      queue_request(ffl_pkg::KIND_ALLOC, 32'h10, 32'h0);
      queue_request(ffl_pkg::KIND_FREE, 32'h100, 32'hFFFF_FFF0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'h20, 32'h0);   // split wraps the offset
      queue_request(ffl_pkg::KIND_FREE, 32'h0, 32'h1234);
      queue_request(ffl_pkg::KIND_ALLOC, 32'h0, 32'h0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'hE0, 32'h0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'hFFFF_FFEF, 32'h0); // end region gone
      queue_request(ffl_pkg::KIND_ALLOC, 32'h0, 32'h0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0);
      queue_request(ffl_pkg::KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(ffl_pkg::KIND_ALLOC, 32'hFFFF_FFFE, 32'h0);
      queue_request(ffl_pkg::KIND_FREE, 32'hFFFF_FFFF, 32'h0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'h0);
      queue_request(ffl_pkg::KIND_ALLOC, 32'h2, 32'h0);
      queue_request(ffl_pkg::KIND_FREE, 32'h0, 32'h0);

      grow = 1'b1;
      tide_left = 0;
      for (ph = 0; ph < 4; ph++) begin
         idle_pct = phase_idle[ph];
         for (k = 0; k < RANDOM_REQUESTS / 4; k++) begin
            while (pending_requests.size() != 0) @(posedge clock);
            if (tide_left == 0) begin
               grow = !grow;
               tide_left = $urandom_range(40, 120);
            end
            tide_left--;
            pending_requests.insert(pending_requests.size(), random_request(grow));
         end
      end

      while (pending_requests.size() != 0 || start || expected_grants.size() != 0)
         @(posedge clock);
      repeat (2 * FREE_SLOTS + 8) @(posedge clock);

      $display("%0d requests taken, %0d results checked", requests_taken, grants_checked);
      $display("exact fits %0d, splits %0d, no fit %0d, frees %0d, dropped on full list %0d",
               n_exact, n_split, n_nofit, n_freed, n_dropped);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
